FILE: rtl/core/mmh_pkg.sv
// Package with shared types, codes and constants of the MurmurHash64B stream core
`timescale 1ns / 1ps

package mmh_pkg;

   // Mixing multiplier and seed value after reset
   localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
   localparam logic [63:0] SEED_RESET = 64'h0000_0000_DEAD_BEEF;

   // Shift amounts of the key mix and of the four finalisation rounds
   localparam int unsigned KEY_SHIFT = 24;
   localparam int unsigned FIN_SH1   = 18;
   localparam int unsigned FIN_SH2   = 22;
   localparam int unsigned FIN_SH3   = 17;
   localparam int unsigned FIN_SH4   = 19;

   // Depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;

   // Word classes
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_TAIL = 2'd1;
   localparam logic [1:0] KIND_FULL = 2'd2;

   // One classified word as it waits in the queue
   typedef struct packed {
      logic [31:0] word;
      logic [1:0]  kind;
      logic        first;
      logic        last;
      logic [30:0] length;
   } entry_type;

   // Queue status towards front and back
   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   // Back status
   typedef struct packed {
      logic busy;
      logic finalising;
   } back_status_type;

endpackage

FILE: rtl/core/mmh_front.sv
// Front: takes request words and classifies them into queue entries
`timescale 1ns / 1ps

module mmh_front (
   input  logic                      push,
   output logic                      full,
   input  logic [31:0]               req_data_word,
   input  logic [2:0]                req_byte_count,
   input  logic                      req_first,
   input  logic                      req_last,
   input  logic [30:0]               req_message_length,
   input  mmh_pkg::queue_status_type q_status,
   output logic                      q_push,
   output mmh_pkg::entry_type        q_entry
);

   // Accept while the queue has room
   assign full   = q_status.full;
   assign q_push = push && !q_status.full;

   // Classify the word and drop bytes above the tail
   always_comb begin
      q_entry.first  = req_first;
      q_entry.last   = req_last;
      q_entry.length = req_message_length;
      case (req_byte_count)
         3'd0: begin
            q_entry.kind = mmh_pkg::KIND_NONE;
            q_entry.word = '0;
         end
         3'd1: begin
            q_entry.kind = mmh_pkg::KIND_TAIL;
            q_entry.word = {24'd0, req_data_word[7:0]};
         end
         3'd2: begin
            q_entry.kind = mmh_pkg::KIND_TAIL;
            q_entry.word = {16'd0, req_data_word[15:0]};
         end
         3'd3: begin
            q_entry.kind = mmh_pkg::KIND_TAIL;
            q_entry.word = {8'd0, req_data_word[23:0]};
         end
         default: begin
            q_entry.kind = mmh_pkg::KIND_FULL;
            q_entry.word = req_data_word;
         end
      endcase
   end

endmodule

FILE: rtl/core/mmh_queue.sv
// Short queue of classified words between front and back
`timescale 1ns / 1ps

module mmh_queue #(
   parameter int unsigned DEPTH = mmh_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mmh_pkg::entry_type        wr_entry,
   input  logic                      pop,
   output mmh_pkg::entry_type        rd_entry,
   output mmh_pkg::queue_status_type status
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   mmh_pkg::entry_type entries_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(DEPTH));
   assign rd_entry     = entries_ff[rd_ptr_ff];

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

FILE: rtl/core/mmh_back.sv
// Back: sequencer around one shared multiplier, accumulators and result register
`timescale 1ns / 1ps

module mmh_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [63:0]               seed,
   input  mmh_pkg::queue_status_type q_status,
   input  mmh_pkg::entry_type        q_entry,
   output logic                      q_pop,
   output logic                      empty,
   input  logic                      pop,
   output logic [63:0]               rsp_hash_value,
   output mmh_pkg::back_status_type  status
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_KEY2 = 4'd1;
   localparam logic [3:0] ST_ACC  = 4'd2;
   localparam logic [3:0] ST_TAIL = 4'd3;
   localparam logic [3:0] ST_FIN1 = 4'd4;
   localparam logic [3:0] ST_FIN2 = 4'd5;
   localparam logic [3:0] ST_FIN3 = 4'd6;
   localparam logic [3:0] ST_FIN4 = 4'd7;
   localparam logic [3:0] ST_OUT  = 4'd8;

   logic [3:0]  state_ff, state_in;
   logic [31:0] h1_ff, h1_in;
   logic [31:0] h2_ff, h2_in;
   logic [31:0] key_ff, key_in;
   logic [31:0] word_ff, word_in;
   logic        last_ff, last_in;
   logic        alt_ff, alt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic [31:0] mul_op;
   logic [31:0] product;

   assign empty          = !rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;
   assign q_pop          = (state_ff == ST_IDLE) && !q_status.empty;
   assign status.busy       = (state_ff != ST_IDLE);
   assign status.finalising = (state_ff == ST_OUT);

   // Pick the operand of the shared multiplier
   always_comb begin
      unique case (state_ff)
         ST_IDLE: mul_op = q_entry.word;
         ST_KEY2: mul_op = key_ff ^ (key_ff >> mmh_pkg::KEY_SHIFT);
         ST_ACC:  mul_op = alt_ff ? h2_ff : h1_ff;
         ST_TAIL: mul_op = h2_ff ^ word_ff;
         ST_FIN1: mul_op = h1_ff ^ (h2_ff >> mmh_pkg::FIN_SH1);
         ST_FIN2: mul_op = h2_ff ^ (h1_ff >> mmh_pkg::FIN_SH2);
         ST_FIN3: mul_op = h1_ff ^ (h2_ff >> mmh_pkg::FIN_SH3);
         ST_FIN4: mul_op = h2_ff ^ (h1_ff >> mmh_pkg::FIN_SH4);
         default: mul_op = '0;
      endcase
   end

   assign product = 32'(mul_op * mmh_pkg::MIX_MUL);

   // Step the sequencer
   always_comb begin
      state_in     = state_ff;
      h1_in        = h1_ff;
      h2_in        = h2_ff;
      key_in       = key_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      alt_in       = alt_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_hash_in  = rsp_hash_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               key_in  = product;
               word_in = q_entry.word;
               last_in = q_entry.last;
               if (q_entry.first) begin
                  h1_in  = seed[31:0] ^ {1'b0, q_entry.length};
                  h2_in  = seed[63:32];
                  alt_in = 1'b0;
               end
               case (q_entry.kind)
                  mmh_pkg::KIND_FULL: state_in = ST_KEY2;
                  mmh_pkg::KIND_TAIL: state_in = ST_TAIL;
                  default:            state_in = q_entry.last ? ST_FIN1 : ST_IDLE;
               endcase
            end
         end
         ST_KEY2: begin
            key_in   = product;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (alt_ff) begin
               h2_in = product ^ key_ff;
            end else begin
               h1_in = product ^ key_ff;
            end
            alt_in   = !alt_ff;
            state_in = last_ff ? ST_FIN1 : ST_IDLE;
         end
         ST_TAIL: begin
            h2_in    = product;
            state_in = last_ff ? ST_FIN1 : ST_IDLE;
         end
         ST_FIN1: begin
            h1_in    = product;
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            h2_in    = product;
            state_in = ST_FIN3;
         end
         ST_FIN3: begin
            h1_in    = product;
            state_in = ST_FIN4;
         end
         ST_FIN4: begin
            h2_in    = product;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Hold until the result register is free or is being popped
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = {h1_ff, h2_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h1_ff        <= '0;
         h2_ff        <= '0;
         alt_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h1_ff        <= h1_in;
         h2_ff        <= h2_in;
         alt_ff       <= alt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      word_ff     <= word_in;
      last_ff     <= last_in;
      rsp_hash_ff <= rsp_hash_in;
   end

endmodule

FILE: rtl/core/murmur64b_stream_hash_core.sv
// Top level of the MurmurHash64B stream core: front, queue, back and seed register
`timescale 1ns / 1ps

// Hashes a message with MurmurHash64B, one little-endian 32-bit word per
// push. The front classifies each word and parks it in a short queue; the
// back works through the queue with a single shared 32x32 multiplier, one
// multiply per cycle unless it waits for work or for the result register. A full
// word takes two key multiplies and one accumulator multiply, a tail word one
// accumulator multiply, an empty word none; the word marked last then adds the
// finalisation multiplies and a load of the result register.
// Pushes are taken while the queue has room, and a finished hash waits in
// its own register until popped. The seed is written through the valid and
// ready port, which is always ready; write it only while the core is idle.

module murmur64b_stream_hash_core #(
   parameter int unsigned QUEUE_DEPTH = mmh_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_data_word,
   input  logic [2:0]  req_byte_count,
   input  logic        req_first,
   input  logic        req_last,
   input  logic [30:0] req_message_length,
   output logic        empty,
   input  logic        pop,
   output logic [63:0] rsp_hash_value,
   input  logic        valid,
   output logic        ready,
   input  logic [63:0] csr_seed
);

   mmh_pkg::queue_status_type q_status;
   mmh_pkg::entry_type        q_wr_entry;
   mmh_pkg::entry_type        q_rd_entry;
   mmh_pkg::back_status_type  back_status;
   logic                      q_push;
   logic                      q_pop;
   logic [63:0]               seed_ff, seed_in;

   // Take seed writes at any time
   assign ready   = 1'b1;
   assign seed_in = (valid && ready) ? csr_seed : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mmh_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mmh_front u_front (
      .push               (push),
      .full               (full),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_first          (req_first),
      .req_last           (req_last),
      .req_message_length (req_message_length),
      .q_status           (q_status),
      .q_push             (q_push),
      .q_entry            (q_wr_entry)
   );

   mmh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .pop      (q_pop),
      .rd_entry (q_rd_entry),
      .status   (q_status)
   );

   mmh_back u_back (
      .clock          (clock),
      .reset          (reset),
      .seed           (seed_ff),
      .q_status       (q_status),
      .q_entry        (q_rd_entry),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .rsp_hash_value (rsp_hash_value),
      .status         (back_status)
   );

   // Back drains only a non-empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("back popped an empty queue");

   // Back takes a new word only while idle
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !back_status.busy)
      else $error("back popped while busy");

   // Front never pushes into a full queue
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("front pushed into a full queue");

   // A new result appears only out of the output step of the back
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $fell(empty) |-> $past(back_status.finalising))
      else $error("result loaded outside the output step");

   // Back leaves the output step once the result register is free
   a_out_progress: assert property (@(posedge clock) disable iff (reset)
      (back_status.finalising && empty) |=> !back_status.finalising)
      else $error("back stuck in the output step");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the MurmurHash64B stream hash core
`timescale 1ns / 1ps

module testbench;

   // One word of the request stream as the core sees it
   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  byte_cnt;
      logic        first;
      logic        last;
      logic [30:0] length;
   } stream_word_type;

   // Cycles to let the back finish words that give no hash
   localparam int unsigned SETTLE_CYCLES = 40;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   logic [31:0] req_data_word;
   logic [2:0]  req_byte_count;
   logic        req_first;
   logic        req_last;
   logic [30:0] req_message_length;
   logic        empty;
   logic        pop;
   logic [63:0] rsp_hash_value;
   logic        valid;
   logic        ready;
   logic [63:0] csr_seed;

   // Hash state as the predictor keeps it
   logic [63:0] seed_value;
   logic [31:0] acc_upper;
   logic [31:0] acc_lower;
   logic        goes_lower;

   logic [63:0] pending_hashes[$];
   logic [63:0] want_hash;
   int          hash_mismatches;
   int          words_sent;
   int          pop_hold;
   bit          quiet_tail;

   murmur64b_stream_hash_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_data_word      (req_data_word),
      .req_byte_count     (req_byte_count),
      .req_first          (req_first),
      .req_last           (req_last),
      .req_message_length (req_message_length),
      .empty              (empty),
      .pop                (pop),
      .rsp_hash_value     (rsp_hash_value),
      .valid              (valid),
      .ready              (ready),
      .csr_seed           (csr_seed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Advance the hash state by one accepted word; return 1 when it yields a hash
   function automatic bit hash_accept(input stream_word_type w, output logic [63:0] hash);
      logic [31:0] k;
      logic [31:0] mask;
      logic [31:0] f1;
      logic [31:0] f2;
      logic [2:0]  n;
      n = (w.byte_cnt > 3'd4) ? 3'd4 : w.byte_cnt;
      hash = '0;
      if (w.first) begin
         acc_upper  = seed_value[31:0] ^ {1'b0, w.length};
         acc_lower  = seed_value[63:32];
         goes_lower = 1'b0;
      end
      if (n == 3'd4) begin
         k = w.word * mmh_pkg::MIX_MUL;
         k = k ^ (k >> mmh_pkg::KEY_SHIFT);
         k = k * mmh_pkg::MIX_MUL;
         if (goes_lower) acc_lower = (acc_lower * mmh_pkg::MIX_MUL) ^ k;
         else acc_upper = (acc_upper * mmh_pkg::MIX_MUL) ^ k;
         goes_lower = !goes_lower;
      end else if (n != 3'd0) begin
         // drop the bytes above the tail
         mask = 32'hFFFF_FFFF >> (8 * (4 - n));
         acc_lower = (acc_lower ^ (w.word & mask)) * mmh_pkg::MIX_MUL;
      end
      if (!w.last) return 1'b0;
      f1 = acc_upper;
      f2 = acc_lower;
      f1 = f1 ^ (f2 >> mmh_pkg::FIN_SH1); f1 = f1 * mmh_pkg::MIX_MUL;
      f2 = f2 ^ (f1 >> mmh_pkg::FIN_SH2); f2 = f2 * mmh_pkg::MIX_MUL;
      f1 = f1 ^ (f2 >> mmh_pkg::FIN_SH3); f1 = f1 * mmh_pkg::MIX_MUL;
      f2 = f2 ^ (f1 >> mmh_pkg::FIN_SH4); f2 = f2 * mmh_pkg::MIX_MUL;
      acc_upper = f1;
      acc_lower = f2;
      hash = {f1, f2};
      return 1'b1;
   endfunction

   function automatic stream_word_type make_word(input logic [31:0] word,
                                                 input logic [2:0] cnt,
                                                 input logic first, input logic last,
                                                 input logic [30:0] length);
      stream_word_type w;
      w.word     = word;
      w.byte_cnt = cnt;
      w.first    = first;
      w.last     = last;
      w.length   = length;
      return w;
   endfunction

   // Send one word, with an occasional gap before it, and log its hash if any
   task automatic send_word(input stream_word_type w);
      logic [63:0] h;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      push               <= 1'b1;
      req_data_word      <= w.word;
      req_byte_count     <= w.byte_cnt;
      req_first          <= w.first;
      req_last           <= w.last;
      req_message_length <= w.length;
      @(posedge clock);
      while (full) @(posedge clock);
      if (hash_accept(w, h)) pending_hashes.push_back(h);
      words_sent++;
   endtask

   // Send a message of nbytes random bytes; length is random unless true_len, extra_close adds a closing word
   task automatic send_message(input int unsigned nbytes, input bit true_len,
                               input bit extra_close);
      stream_word_type w;
      int unsigned     left;
      int unsigned     take;
      bit              opened;
      left   = nbytes;
      opened = 1'b0;
      do begin
         take       = (left >= 4) ? 4 : left;
         left       = left - take;
         w.word     = $urandom;
         w.byte_cnt = (take == 4 && $urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                               : 3'(take);
         w.first    = !opened;
         w.last     = (left == 0) && !extra_close;
         w.length   = true_len ? 31'(nbytes) : 31'($urandom);
         send_word(w);
         opened = 1'b1;
      end while (left != 0);
      // close with an empty word after the data
      if (extra_close) send_word(make_word($urandom, 3'd0, 1'b0, 1'b1, 31'($urandom)));
   endtask

   task automatic send_noise();
      send_word(make_word($urandom, 3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom),
                          31'($urandom)));
   endtask

   // Hold off until every hash is in and the back has gone quiet
   task automatic drain_and_settle();
      push <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_seed(input logic [63:0] v);
      csr_seed <= v;
      valid    <= 1'b1;
      @(posedge clock);
      while (!ready) @(posedge clock);
      valid      <= 1'b0;
      seed_value = v;
   endtask

   // Edges of the fields, tails, saturation, empty message and continuation
   task automatic test_directed_edges();
      stream_word_type list[17];
      list = '{
         make_word(32'h0000_0000, 3'd0, 1'b1, 1'b1, 31'd0),
         make_word(32'h0000_0000, 3'd4, 1'b1, 1'b1, 31'd4),
         make_word(32'hFFFF_FFFF, 3'd4, 1'b1, 1'b1, 31'd4),
         make_word(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1, 31'd1),
         make_word(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1, 31'd2),
         make_word(32'hFFFF_FFFF, 3'd3, 1'b1, 1'b1, 31'd3),
         make_word(32'hA5A5_A5A5, 3'd7, 1'b1, 1'b1, 31'h7FFF_FFFF),
         make_word(32'h0123_4567, 3'd5, 1'b1, 1'b0, 31'd0),
         make_word(32'h89AB_CDEF, 3'd6, 1'b0, 1'b0, 31'h7FFF_FFFF),
         make_word(32'h0000_0000, 3'd3, 1'b0, 1'b1, 31'd0),
         make_word(32'hDEAD_BEEF, 3'd4, 1'b0, 1'b1, 31'd11),
         make_word(32'hFFFF_FFFF, 3'd0, 1'b0, 1'b1, 31'h7FFF_FFFF),
         make_word(32'h8000_0001, 3'd4, 1'b1, 1'b0, 31'd10),
         make_word(32'h7FFF_FFFE, 3'd2, 1'b0, 1'b0, 31'd0),
         make_word(32'h5555_5555, 3'd4, 1'b0, 1'b1, 31'd0),
         make_word(32'hAAAA_AAAA, 3'd0, 1'b1, 1'b0, 31'h5555_5555),
         make_word(32'h0000_00FF, 3'd1, 1'b0, 1'b1, 31'h2AAA_AAAA)
      };
      foreach (list[i]) send_word(list[i]);
   endtask

   // Extreme and random seeds, each with a few short messages
   task automatic test_seed_extremes();
      logic [63:0] seeds[5];
      seeds = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
                {$urandom, $urandom}, mmh_pkg::SEED_RESET};
      foreach (seeds[i]) begin
         drain_and_settle();
         write_seed(seeds[i]);
         send_message(0, 1'b1, 1'b0);
         repeat (3) send_message($urandom_range(1, 16), 1'b1, 1'b0);
      end
   endtask

   // Mostly well-formed messages with random content, some noise, seed changes between phases
   task automatic test_random_traffic();
      int start;
      int r;
      for (int phase = 0; phase < 4; phase++) begin
         drain_and_settle();
         write_seed({$urandom, $urandom});
         start = words_sent;
         while (words_sent < start + 100) begin
            r = $urandom_range(0, 99);
            if (r < 15) send_noise();
            else if (r < 90)
               send_message($urandom_range(0, 24), $urandom_range(0, 9) != 0,
                            $urandom_range(0, 9) == 0);
            else send_message($urandom_range(25, 64), 1'b1, $urandom_range(0, 9) == 0);
         end
      end
   endtask

   // Back-to-back traffic with no gaps and no pop stalls
   task automatic test_back_to_back();
      int start;
      quiet_tail = 1'b1;
      start = words_sent;
      while (words_sent < start + 60) send_message($urandom_range(0, 20), 1'b1, 1'b0);
   endtask

   // Pop side: stall in random bursts, never once the tail starts
   always @(posedge clock) begin
      if (reset) begin
         pop      <= 1'b0;
         pop_hold = 0;
      end else if (pop_hold != 0) begin
         pop_hold--;
         pop <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         pop_hold = $urandom_range(0, 4);
         pop      <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // Compare each popped hash with the oldest one predicted
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_hashes.size() == 0) begin
            hash_mismatches++;
            if (hash_mismatches <= 10)
               $display("unexpected hash word: actual %h", rsp_hash_value);
         end else begin
            want_hash = pending_hashes.pop_front();
            if (rsp_hash_value !== want_hash) begin
               hash_mismatches++;
               if (hash_mismatches <= 10)
                  $display("hash_value mismatch: expected %h actual %h",
                           want_hash, rsp_hash_value);
            end
         end
      end
   end

   initial begin
      reset              = 1'b1;
      push               = 1'b0;
      valid              = 1'b0;
      csr_seed           = '0;
      req_data_word      = '0;
      req_byte_count     = '0;
      req_first          = 1'b0;
      req_last           = 1'b0;
      req_message_length = '0;
      seed_value         = mmh_pkg::SEED_RESET;
      acc_upper          = '0;
      acc_lower          = '0;
      goes_lower         = 1'b0;
      hash_mismatches    = 0;
      words_sent         = 0;
      quiet_tail         = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_seed_extremes();
      test_random_traffic();
      test_back_to_back();
      push <= 1'b0;
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (hash_mismatches == 0 && pending_hashes.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
